// ===== rtl/core/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and helpers for the centered FIR convolver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

  localparam int MAX_TAPS    = 15;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_W      = 16;
  localparam int CNT_W       = 4;
  localparam int ADDR_W      = $clog2(MAX_TAPS);
  localparam int PROD_W      = SAMPLE_BITS + COEF_W;
  localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int FRAC_W      = 15;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam int TAP_LIM     = (MAX_TAPS % 2 == 1) ? MAX_TAPS : MAX_TAPS - 1;

  localparam logic FUNC_TAP    = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } cfc_state_e;

  function automatic logic [CNT_W-1:0] taps_in_use(input logic [CNT_W-1:0] tc);
    logic [CNT_W-1:0] k;
    k = tc | CNT_W'(1);
    if (k > CNT_W'(TAP_LIM)) begin
      k = CNT_W'(TAP_LIM);
    end
    return k;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_next(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(MAX_TAPS - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_prev(input logic [ADDR_W-1:0] p);
    return (p == '0) ? ADDR_W'(MAX_TAPS - 1) : p - ADDR_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cfc_ram.sv =====
// ----------------------------------------------------------------------------
// cfc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/centered_fir_convolver_top.sv =====
// ----------------------------------------------------------------------------
// centered_fir_convolver_top
// Centered FIR filter over zero-padded sample runs, odd kernel, Q1.15 taps.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | tvalid/tready          | tdata: tap_index, tap_value, sample;
//           |     |                        | tuser: func; tlast: last_sample
//  m_axis   | out | tvalid/tready          | tdata: filtered; tuser: saturated;
//           |     |                        | tlast: last_out
//  cfg      | in  | cfg_we_i               | cfg_data_i: tap_count
//
//  A sample that yields an output runs one shared multiply-accumulate, which
//  reads one coefficient and one window entry per cycle from two RAMs, each
//  with one write and one registered read port; then the pipeline drains and
//  the sum is rounded. After the last sample, zeros are shifted into the window
//  to flush the remaining outputs. Reset clears all control state; the window
//  needs no clearing pass. A full output register holds the sequencer in FINISH.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_fir_convolver_top
  import cfc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  // [3:0] tap_index, [19:4] tap_value, [35:20] sample, [39:36] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] func
  input  wire logic                   s_axis_tuser_i,
  input  wire logic                   s_axis_tlast_i,
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [15:0] filtered
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] saturated
  output      logic                   m_axis_tuser_o,
  output      logic                   m_axis_tlast_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CNT_W-1:0]       cfg_data_i
);

  cfc_state_e state_q, state_d;

  logic [CNT_W-1:0]  tap_count_q;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0]  seen_q, seen_d;
  logic [ADDR_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  taps_q, taps_d;
  logic [CNT_W-1:0]  half_q, half_d;
  logic              last_q, last_d;
  logic [MAX_TAPS-1:0] cvld_q;
  logic              v1_q, v2_q;
  logic              wmask_q, cmask_q;
  logic              out_valid_q;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;
  logic                     out_sat_q, out_last_q;

  logic [ADDR_W-1:0]      tap_idx;
  logic [COEF_W-1:0]      tap_val;
  logic [SAMPLE_BITS-1:0] smp_val;
  logic                   accept, smp_acc, tap_acc;
  logic [CNT_W-1:0]       taps_now, half_now, seen_inc;
  logic                   win_we, coef_we;
  logic [SAMPLE_BITS-1:0] win_wdata, win_rdata;
  logic [COEF_W-1:0]      coef_rdata;
  logic                   mac_start, out_load, out_last_d;
  logic                   tap_idx_ok;

  logic signed [ACC_W-1:0]  rnd, q_full;
  logic                     sat_hi, sat_lo;
  logic [OUT_TDATA_W-1:0]   filt_d;

  localparam logic signed [ACC_W-1:0] RND_K = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] MAXV  = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] MINV  = -MAXV - ACC_W'(1);

  assign tap_idx    = s_axis_tdata_i[ADDR_W-1:0];
  assign tap_val    = s_axis_tdata_i[19:4];
  assign smp_val    = s_axis_tdata_i[35:20];
  assign tap_idx_ok = s_axis_tdata_i[3:0] < 4'(MAX_TAPS);

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign smp_acc  = accept && (s_axis_tuser_i == FUNC_SAMPLE);
  assign tap_acc  = accept && (s_axis_tuser_i == FUNC_TAP);
  assign taps_now = taps_in_use(tap_count_q);
  assign half_now = taps_now >> 1;
  assign seen_inc = (seen_q == CNT_W'(MAX_TAPS)) ? seen_q : seen_q + CNT_W'(1);
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready_i);
  assign out_last_d = last_q && (rem_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          if (seen_inc > half_now) begin
            state_d = ST_MAC;
          end else if (s_axis_tlast_i) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (seen_inc > half_q) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (j_q == taps_q - CNT_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = (rem_q != '0) ? ST_FLUSH : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    win_we    = smp_acc || (state_q == ST_FLUSH);
    win_wdata = smp_acc ? smp_val : '0;
    coef_we   = tap_acc && tap_idx_ok;
    mac_start = (state_d == ST_MAC) && (state_q != ST_MAC);
    wp_d   = win_we ? ptr_next(wp_q) : wp_q;
    seen_d = win_we ? seen_inc : seen_q;
    if (out_load && out_last_d) begin
      seen_d = '0;
    end
    rem_d  = rem_q;
    last_d = last_q;
    taps_d = taps_q;
    half_d = half_q;
    if (smp_acc) begin
      last_d = s_axis_tlast_i;
      rem_d  = s_axis_tlast_i ? half_now : '0;
      taps_d = taps_now;
      half_d = half_now;
    end else if (state_q == ST_FLUSH) begin
      rem_d = rem_q - CNT_W'(1);
    end
    rp_d = rp_q;
    j_d  = j_q;
    if (mac_start) begin
      rp_d = wp_q;
      j_d  = '0;
    end else if (state_q == ST_MAC) begin
      rp_d = ptr_prev(rp_q);
      j_d  = j_q + CNT_W'(1);
    end
  end

  cfc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (tap_idx),
    .wdata_i (tap_val),
    .raddr_i (j_q[ADDR_W-1:0]),
    .rdata_o (coef_rdata)
  );

  cfc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (wp_q),
    .wdata_i (win_wdata),
    .raddr_i (rp_q),
    .rdata_o (win_rdata)
  );

  always_comb begin
    rnd    = acc_q + RND_K;
    q_full = rnd >>> FRAC_W;
    sat_hi = q_full > MAXV;
    sat_lo = q_full < MINV;
    if (sat_hi) begin
      filt_d = MAXV[OUT_TDATA_W-1:0];
    end else if (sat_lo) begin
      filt_d = MINV[OUT_TDATA_W-1:0];
    end else begin
      filt_d = q_full[OUT_TDATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= CNT_W'(1);
      wp_q        <= '0;
      seen_q      <= '0;
      rp_q        <= '0;
      j_q         <= '0;
      rem_q       <= '0;
      taps_q      <= CNT_W'(1);
      half_q      <= '0;
      last_q      <= 1'b0;
      cvld_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      wmask_q     <= 1'b0;
      cmask_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tap_count_q <= cfg_data_i;
      end
      wp_q   <= wp_d;
      seen_q <= seen_d;
      rp_q   <= rp_d;
      j_q    <= j_d;
      rem_q  <= rem_d;
      taps_q <= taps_d;
      half_q <= half_d;
      last_q <= last_d;
      if (coef_we) begin
        cvld_q[tap_idx] <= 1'b1;
      end
      v1_q <= (state_q == ST_MAC);
      v2_q <= v1_q;
      if (state_q == ST_MAC) begin
        wmask_q <= j_q < seen_q;
        cmask_q <= cvld_q[j_q[ADDR_W-1:0]];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(wmask_q ? win_rdata : '0) * $signed(cmask_q ? coef_rdata : '0);
    if (mac_start) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (out_load) begin
      out_data_q <= filt_d;
      out_sat_q  <= sat_hi || sat_lo;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;
  assign m_axis_tlast_o  = out_last_q;

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < ADDR_W'(MAX_TAPS))
    else $error("window pointer out of range");

  a_mac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (j_q < taps_q))
    else $error("tap counter beyond tap count");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o)
    else $error("loaded result not presented");

  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (seen_q == '0 && state_q == ST_IDLE))
    else $error("sequence state not cleared after last result");

  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (!v1_q && !v2_q))
    else $error("result taken before pipeline drained");

endmodule

`default_nettype wire
